/* rtl/ibfc_pkg.sv */
package ibfc_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SESS_W  = 9;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned PROD_W  = LEVEL_W + DUR_W;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [KIND_W-1:0] KIND_INIT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PRESS    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEVEL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SESSIONS = 3'd5;

  localparam logic [1:0] MODE_AWAKE      = 2'd0;
  localparam logic [1:0] MODE_FADING_OUT = 2'd1;
  localparam logic [1:0] MODE_ASLEEP     = 2'd2;
  localparam logic [1:0] MODE_FADING_IN  = 2'd3;

  localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SESSION_TIMEOUT = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_PERIOD     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FADE_OUT_DUR    = 3'd3;
  localparam logic [IDX_W-1:0] REG_FADE_IN_DUR     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLEEP_EXT_PWR   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEFAULT_LEVEL   = 3'd6;

  localparam logic [TIME_W-1:0]  RST_IDLE_TIMEOUT    = 32'd60000;
  localparam logic [TIME_W-1:0]  RST_SESSION_TIMEOUT = 32'd30000;
  localparam logic [DUR_W-1:0]   RST_STEP_PERIOD     = 16'd20;
  localparam logic [DUR_W-1:0]   RST_FADE_OUT_DUR    = 16'd1000;
  localparam logic [DUR_W-1:0]   RST_FADE_IN_DUR     = 16'd300;
  localparam logic [LEVEL_W-1:0] RST_DEFAULT_LEVEL   = 8'd200;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX           = 8'd255;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DUR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/idle_backlight_fade_controller.sv */
// Flow: an input beat is captured, executed, then loaded into the output register;
//   a tick that interpolates a fade step first runs the restoring divider, which
//   yields one quotient bit a cycle. One item is handled at a time: in_stall is high
//   from acceptance until the result is loaded into the output register.
// Reset (rst, synchronous): registers take their default values, mode is awake,
//   timers clear, awake and fade start levels become 200, session status unknown.
module idle_backlight_fade_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ibfc_pkg::KIND_W-1:0]  kind,
  input  logic [ibfc_pkg::TIME_W-1:0]  now_ms,
  input  logic [ibfc_pkg::LEVEL_W-1:0] level,
  input  logic signed [ibfc_pkg::SESS_W-1:0] sessions,
  input  logic                         power_present,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         brightness_valid,
  output logic [ibfc_pkg::LEVEL_W-1:0] brightness,
  output logic                         press_swallowed,
  output logic                         asleep,
  input  logic                         cfg_we,
  input  logic [ibfc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ibfc_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;

  logic [ibfc_pkg::TIME_W-1:0]  idle_timeout;
  logic [ibfc_pkg::TIME_W-1:0]  session_idle_timeout;
  logic [ibfc_pkg::DUR_W-1:0]   fade_step_period;
  logic [ibfc_pkg::DUR_W-1:0]   fade_out_duration;
  logic [ibfc_pkg::DUR_W-1:0]   fade_in_duration;
  logic                         sleep_on_external_power;
  logic [ibfc_pkg::LEVEL_W-1:0] default_level;

  logic [1:0]                   mode;
  logic [ibfc_pkg::TIME_W-1:0]  last_activity_time;
  logic [ibfc_pkg::TIME_W-1:0]  fade_start_time;
  logic [ibfc_pkg::TIME_W-1:0]  fade_step_time;
  logic [ibfc_pkg::LEVEL_W-1:0] fade_start_level;
  logic [ibfc_pkg::LEVEL_W-1:0] fade_end_level;
  logic [ibfc_pkg::LEVEL_W-1:0] awake_level;
  logic signed [ibfc_pkg::SESS_W-1:0] session_status;

  logic [ibfc_pkg::KIND_W-1:0]  it_kind;
  logic [ibfc_pkg::TIME_W-1:0]  it_now;
  logic [ibfc_pkg::LEVEL_W-1:0] it_level;
  logic [ibfc_pkg::SESS_W-1:0]  it_sessions;
  logic                         it_power;

  logic                         res_valid;
  logic [ibfc_pkg::LEVEL_W-1:0] res_bright;
  logic                         res_swallow;
  logic                         res_asleep;
  logic                         div_neg;
  logic [ibfc_pkg::LEVEL_W-1:0] div_base;

  logic [1:0]                   mode_next;
  logic [ibfc_pkg::TIME_W-1:0]  last_next;
  logic [ibfc_pkg::TIME_W-1:0]  fstart_next;
  logic [ibfc_pkg::TIME_W-1:0]  fstep_next;
  logic [ibfc_pkg::LEVEL_W-1:0] fsl_next;
  logic [ibfc_pkg::LEVEL_W-1:0] fel_next;
  logic [ibfc_pkg::LEVEL_W-1:0] awake_next;
  logic                         valid_next;
  logic [ibfc_pkg::LEVEL_W-1:0] bright_next;
  logic                         swallow_next;
  logic                         need_div;
  logic                         hold;
  logic                         dark;
  logic [ibfc_pkg::TIME_W-1:0]  limit;
  logic [ibfc_pkg::TIME_W-1:0]  elapsed;
  logic [ibfc_pkg::DUR_W-1:0]   dur;
  logic signed [ibfc_pkg::LEVEL_W:0] span;
  logic [ibfc_pkg::LEVEL_W-1:0] span_mag;
  logic signed [ibfc_pkg::LEVEL_W+1:0] interp;

  ibfc_pkg::div_req_t div_req;
  ibfc_pkg::div_rsp_t div_rsp;

  ibfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    mode_next    = mode;
    last_next    = last_activity_time;
    fstart_next  = fade_start_time;
    fstep_next   = fade_step_time;
    fsl_next     = fade_start_level;
    fel_next     = fade_end_level;
    awake_next   = awake_level;
    valid_next   = 1'b0;
    bright_next  = '0;
    swallow_next = 1'b0;
    need_div     = 1'b0;
    limit        = '0;
    elapsed      = '0;
    dur          = '0;
    span         = '0;
    dark         = (mode == ibfc_pkg::MODE_ASLEEP) || (mode == ibfc_pkg::MODE_FADING_OUT);
    hold         = (session_status > 0) ||
                   (!sleep_on_external_power && it_power && session_status < 0);
    case (it_kind)
      ibfc_pkg::KIND_INIT: begin
        mode_next   = ibfc_pkg::MODE_AWAKE;
        last_next   = it_now;
        valid_next  = 1'b1;
        bright_next = awake_level;
      end
      ibfc_pkg::KIND_TICK: begin
        if (hold) begin
          last_next = it_now;
          if (dark) begin
            fsl_next    = '0;
            fel_next    = awake_level;
            fstart_next = it_now;
            fstep_next  = it_now;
            mode_next   = ibfc_pkg::MODE_FADING_IN;
          end
        end
        if (mode_next == ibfc_pkg::MODE_AWAKE) begin
          limit = (session_status >= 0) ? session_idle_timeout : idle_timeout;
          if ((it_now - last_next) >= limit) begin
            fsl_next    = awake_level;
            fel_next    = '0;
            fstart_next = it_now;
            fstep_next  = it_now;
            mode_next   = ibfc_pkg::MODE_FADING_OUT;
          end
        end else if (mode_next == ibfc_pkg::MODE_FADING_OUT ||
                     mode_next == ibfc_pkg::MODE_FADING_IN) begin
          if ((it_now - fstep_next) >= {16'd0, fade_step_period}) begin
            dur = (mode_next == ibfc_pkg::MODE_FADING_OUT) ? fade_out_duration
                                                           : fade_in_duration;
            elapsed    = it_now - fstart_next;
            fstep_next = it_now;
            valid_next = 1'b1;
            if (elapsed >= {16'd0, dur}) begin
              bright_next = fel_next;
              mode_next   = (mode_next == ibfc_pkg::MODE_FADING_OUT) ?
                            ibfc_pkg::MODE_ASLEEP : ibfc_pkg::MODE_AWAKE;
            end else begin
              span     = $signed({1'b0, fel_next}) - $signed({1'b0, fsl_next});
              need_div = 1'b1;
            end
          end
        end
      end
      ibfc_pkg::KIND_ACTIVITY: begin
        last_next = it_now;
        if (dark) begin
          fsl_next    = '0;
          fel_next    = awake_level;
          fstart_next = it_now;
          fstep_next  = it_now;
          mode_next   = ibfc_pkg::MODE_FADING_IN;
        end
      end
      ibfc_pkg::KIND_PRESS: begin
        last_next = it_now;
        if (dark) begin
          fsl_next     = '0;
          fel_next     = awake_level;
          fstart_next  = it_now;
          fstep_next   = it_now;
          mode_next    = ibfc_pkg::MODE_FADING_IN;
          swallow_next = 1'b1;
        end else if (mode == ibfc_pkg::MODE_FADING_IN) begin
          swallow_next = 1'b1;
        end
      end
      ibfc_pkg::KIND_LEVEL: begin
        awake_next = it_level;
        if (mode == ibfc_pkg::MODE_AWAKE) begin
          valid_next  = 1'b1;
          bright_next = it_level;
        end
      end
      default: begin
      end
    endcase
  end

  assign span_mag = span[ibfc_pkg::LEVEL_W] ? ibfc_pkg::LEVEL_W'(-span)
                                            : span[ibfc_pkg::LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    div_req.start    <= (state == S_EXEC) && need_div;
    div_req.dividend <= span_mag * elapsed[ibfc_pkg::DUR_W-1:0];
    div_req.divisor  <= dur;
  end

  assign interp = div_neg ?
    $signed({2'b00, div_base}) - $signed({2'b00, div_rsp.quotient}) :
    $signed({2'b00, div_base}) + $signed({2'b00, div_rsp.quotient});

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= S_IDLE;
      out_valid               <= 1'b0;
      idle_timeout            <= ibfc_pkg::RST_IDLE_TIMEOUT;
      session_idle_timeout    <= ibfc_pkg::RST_SESSION_TIMEOUT;
      fade_step_period        <= ibfc_pkg::RST_STEP_PERIOD;
      fade_out_duration       <= ibfc_pkg::RST_FADE_OUT_DUR;
      fade_in_duration        <= ibfc_pkg::RST_FADE_IN_DUR;
      sleep_on_external_power <= 1'b0;
      default_level           <= ibfc_pkg::RST_DEFAULT_LEVEL;
      mode                    <= ibfc_pkg::MODE_AWAKE;
      last_activity_time      <= '0;
      fade_start_time         <= '0;
      fade_step_time          <= '0;
      fade_start_level        <= ibfc_pkg::RST_DEFAULT_LEVEL;
      fade_end_level          <= '0;
      awake_level             <= ibfc_pkg::RST_DEFAULT_LEVEL;
      session_status          <= -9'sd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ibfc_pkg::REG_IDLE_TIMEOUT:    idle_timeout <= cfg_data;
          ibfc_pkg::REG_SESSION_TIMEOUT: session_idle_timeout <= cfg_data;
          ibfc_pkg::REG_STEP_PERIOD:     fade_step_period <= cfg_data[ibfc_pkg::DUR_W-1:0];
          ibfc_pkg::REG_FADE_OUT_DUR:    fade_out_duration <= cfg_data[ibfc_pkg::DUR_W-1:0];
          ibfc_pkg::REG_FADE_IN_DUR:     fade_in_duration <= cfg_data[ibfc_pkg::DUR_W-1:0];
          ibfc_pkg::REG_SLEEP_EXT_PWR:   sleep_on_external_power <= cfg_data[0];
          ibfc_pkg::REG_DEFAULT_LEVEL:   default_level <= cfg_data[ibfc_pkg::LEVEL_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          mode               <= mode_next;
          last_activity_time <= last_next;
          fade_start_time    <= fstart_next;
          fade_step_time     <= fstep_next;
          fade_start_level   <= fsl_next;
          fade_end_level     <= fel_next;
          awake_level        <= awake_next;
          if (it_kind == ibfc_pkg::KIND_SESSIONS) begin
            session_status <= $signed(it_sessions);
          end
          state <= need_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      it_kind     <= kind;
      it_now      <= now_ms;
      it_level    <= level;
      it_sessions <= sessions;
      it_power    <= power_present;
    end
    if (state == S_EXEC) begin
      res_valid   <= valid_next;
      res_bright  <= bright_next;
      res_swallow <= swallow_next;
      res_asleep  <= (mode_next == ibfc_pkg::MODE_ASLEEP) ||
                     (mode_next == ibfc_pkg::MODE_FADING_OUT);
      div_neg     <= span[ibfc_pkg::LEVEL_W];
      div_base    <= fsl_next;
    end
    if (state == S_DIV && div_rsp.done) begin
      if (interp < 0) begin
        res_bright <= '0;
      end else if (interp > $signed({2'b00, ibfc_pkg::LEVEL_MAX})) begin
        res_bright <= ibfc_pkg::LEVEL_MAX;
      end else begin
        res_bright <= interp[ibfc_pkg::LEVEL_W-1:0];
      end
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      brightness_valid <= res_valid;
      brightness       <= res_valid ? res_bright : '0;
      press_swallowed  <= res_swallow;
      asleep           <= res_asleep;
    end
  end

endmodule

/* rtl/ibfc_div.sv */
module ibfc_div (
  input  logic              clk,
  input  logic              rst,
  input  ibfc_pkg::div_req_t req,
  output ibfc_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(ibfc_pkg::PROD_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ibfc_pkg::PROD_W - 1);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [ibfc_pkg::PROD_W-1:0] acc;
  logic [ibfc_pkg::DUR_W-1:0]  rem;
  logic [ibfc_pkg::DUR_W-1:0]  divisor;
  logic [ibfc_pkg::DUR_W:0]    trial;
  logic                        fits;

  assign trial = {rem, acc[ibfc_pkg::PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == LAST_STEP);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? ibfc_pkg::DUR_W'(trial - {1'b0, divisor})
                  : trial[ibfc_pkg::DUR_W-1:0];
      acc <= {acc[ibfc_pkg::PROD_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc[ibfc_pkg::LEVEL_W-1:0];

endmodule
